// ===== rtl/core/bounded_shifting_list_top_macros.svh =====
// Assertion macros shared by the bounded shifting list RTL.
// Included by bounded_shifting_list_top, which carries the concurrent assertions; depends on nothing.
`ifndef BOUNDED_SHIFTING_LIST_TOP_MACROS_SVH
`define BOUNDED_SHIFTING_LIST_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BSL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/bsl_pkg.sv =====
// Package for the bounded shifting list: operation and status codes, cell control.
// Used by bsl_cell and bounded_shifting_list_top; depends on nothing.
`timescale 1ns / 1ps
package bsl_pkg;

	typedef enum logic [2:0] {
		K_APPEND   = 3'd0,
		K_INSERT   = 3'd1,
		K_REM_VAL  = 3'd2,
		K_REM_AT   = 3'd3,
		K_POP      = 3'd4,
		K_CONTAINS = 3'd5,
		K_READ_AT  = 3'd6,
		K_CLEAR    = 3'd7
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_RANGE     = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD      = 2'd0,
		CELL_INSERT    = 2'd1,
		CELL_DEL_AT    = 2'd2,
		CELL_DEL_MATCH = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     cmp_en;
	} cell_ctl_t;

endpackage

// ===== rtl/core/bsl_cell.sv =====
// One list cell: holds one entry, compares it with the search value and shifts.
// Depends on bsl_pkg.
`timescale 1ns / 1ps
module bsl_cell import bsl_pkg::*; #(
	parameter int EW  = 32,
	parameter int CW  = 6,
	parameter int POS = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cell_ctl_t     ctl,
	input  logic [CW-1:0] pos,
	input  logic [CW-1:0] cnt,
	input  logic [EW-1:0] val,
	input  logic [EW-1:0] left,
	input  logic [EW-1:0] right,
	input  logic          hit_in,
	output logic [EW-1:0] entry,
	output logic          hit_out
);

	localparam logic [CW-1:0] POS_V = CW'(POS);

	logic [EW-1:0] entry_q;
	logic          match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.cmp_en) begin
			match_q <= (entry_q == val) && (POS_V < cnt);
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CELL_INSERT: begin
				if (POS_V == pos) begin
					entry_q <= val;
				end else if (POS_V > pos) begin
					entry_q <= left;
				end
			end
			CELL_DEL_AT: begin
				if (POS_V >= pos) begin
					entry_q <= right;
				end
			end
			CELL_DEL_MATCH: begin
				if (hit_in || match_q) begin
					entry_q <= right;
				end
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

	assign entry   = entry_q;
	assign hit_out = hit_in || match_q;

endmodule

// ===== rtl/core/bounded_shifting_list_top.sv =====
// Top level of the bounded shifting list: handshakes, control and the row of cells.
// Depends on bsl_pkg, bsl_cell and bounded_shifting_list_top_macros.svh.
//
//   channel | direction | handshake            | payload
//   in      | into      | in_valid / in_ready  | kind, index, value
//   out     | out of    | out_valid / out_ready| status, data, count
//
// On the accepting edge every cell registers the compare of its entry with the value; the
// first-match chain then settles, and on the commit edge, once the output register is free,
// the cells shift together. A new item is accepted only after the previous one has committed.
// Reset clears the entry count and the busy and output valid flags; entries are not cleared.
// While a result waits at the output, the next item is still accepted and compared; it is
// held busy until the output register is free.
`timescale 1ns / 1ps
module bounded_shifting_list_top import bsl_pkg::*; #(
	parameter int CAPACITY    = 32,
	parameter int ENTRY_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [4:0]  index,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [31:0] data,
	output logic [5:0]  count
);

	`include "bounded_shifting_list_top_macros.svh"

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int IW = (CW > 5) ? CW : 5;
	localparam int EW = ENTRY_WIDTH;
	localparam logic [CW-1:0] CAP_V = CW'(CAPACITY);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	kind_t         kind_s1;
	logic [4:0]    idx_s1;
	logic [EW-1:0] val_s1;
	logic [AW-1:0] rd_pos_s1;

	logic          out_valid_q;
	status_t       status_q;
	logic [31:0]   data_q;
	logic [5:0]    count_q;

	logic          accept;
	logic          commit;
	logic [EW+31:0] val_wide;
	logic [EW-1:0] in_val;

	logic [EW-1:0] cell_entry [CAPACITY];
	logic [CAPACITY:0] hit;
	cell_ctl_t     ctl;
	cell_op_t      op_n;
	logic [CW-1:0] tgt_n;
	logic [CW-1:0] cnt_n;
	status_t       status_n;
	logic [31:0]   data_n;
	logic [EW+31:0] rd_wide;
	logic [CW+5:0] cnt_wide;
	logic          idx_ge;
	logic          full;
	logic          found;

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;
	assign commit   = busy_q && (!out_valid_q || out_ready);

	assign val_wide = {{EW{1'b0}}, value};
	assign in_val   = val_wide[EW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (commit) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind_t'(kind);
			idx_s1  <= index;
			val_s1  <= in_val;
			if (kind_t'(kind) == K_POP) begin
				rd_pos_s1 <= AW'(cnt_q - CW'(1));
			end else begin
				rd_pos_s1 <= AW'(index);
			end
		end
	end

	assign ctl.cmp_en = accept;
	assign ctl.op     = commit ? op_n : CELL_HOLD;
	assign hit[0]     = 1'b0;

	for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
		logic [EW-1:0] left_d;
		logic [EW-1:0] right_d;
		if (gi == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_entry[gi-1];
		end
		if (gi == CAPACITY - 1) begin : g_last
			assign right_d = cell_entry[gi];
		end else begin : g_mid_r
			assign right_d = cell_entry[gi+1];
		end
		bsl_cell #(
			.EW  (EW),
			.CW  (CW),
			.POS (gi)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.pos     (tgt_n),
			.cnt     (cnt_q),
			.val     (busy_q ? val_s1 : in_val),
			.left    (left_d),
			.right   (right_d),
			.hit_in  (hit[gi]),
			.entry   (cell_entry[gi]),
			.hit_out (hit[gi+1])
		);
	end

	assign found   = hit[CAPACITY];
	assign full    = (cnt_q >= CAP_V);
	assign idx_ge  = IW'(idx_s1) >= IW'(cnt_q);
	assign rd_wide = {32'd0, cell_entry[rd_pos_s1]};

	always_comb begin
		op_n     = CELL_HOLD;
		tgt_n    = cnt_q;
		cnt_n    = cnt_q;
		status_n = ST_OK;
		data_n   = '0;
		unique case (kind_s1)
			K_APPEND: begin
				if (full) begin
					status_n = ST_FULL;
				end else begin
					op_n  = CELL_INSERT;
					cnt_n = cnt_q + CW'(1);
				end
			end
			K_INSERT: begin
				if (full) begin
					status_n = ST_FULL;
				end else begin
					op_n  = CELL_INSERT;
					tgt_n = idx_ge ? cnt_q : CW'(idx_s1);
					cnt_n = cnt_q + CW'(1);
				end
			end
			K_REM_VAL: begin
				if (found) begin
					op_n  = CELL_DEL_MATCH;
					cnt_n = cnt_q - CW'(1);
				end else begin
					status_n = ST_NOT_FOUND;
				end
			end
			K_REM_AT: begin
				if (idx_ge) begin
					status_n = ST_RANGE;
				end else begin
					op_n  = CELL_DEL_AT;
					tgt_n = CW'(idx_s1);
					cnt_n = cnt_q - CW'(1);
				end
			end
			K_POP: begin
				if (cnt_q == '0) begin
					status_n = ST_EMPTY;
				end else begin
					cnt_n  = cnt_q - CW'(1);
					data_n = rd_wide[31:0];
				end
			end
			K_CONTAINS: begin
				if (!found) begin
					status_n = ST_NOT_FOUND;
				end
			end
			K_READ_AT: begin
				if (idx_ge) begin
					status_n = ST_RANGE;
				end else begin
					data_n = rd_wide[31:0];
				end
			end
			default: begin
				cnt_n = '0;
			end
		endcase
	end

	assign cnt_wide = {6'd0, cnt_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				cnt_q       <= cnt_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q <= status_n;
			data_q   <= data_n;
			count_q  <= cnt_wide[5:0];
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign data      = data_q;
	assign count     = count_q;

	`BSL_ASSERT_NXT(a_accept_busy, clk, arst_n, accept, busy_q, "accepted beat did not mark busy")
	`BSL_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CAP_V, "entry count above capacity")
	`BSL_ASSERT_NXT(a_commit_out, clk, arst_n, commit, out_valid_q, "result not presented")
	`BSL_ASSERT_NXT(a_cnt_hold, clk, arst_n, !commit, $stable(cnt_q), "count moved without commit")
	`BSL_ASSERT_IMP(a_err_zero, clk, arst_n, out_valid_q && (status_q != ST_OK), data_q == '0,
		"non-zero data with error status")

endmodule

// ===== sim/bounded_shifting_list_top_test.sv =====
// Self-checking testbench for bounded_shifting_list_top: random and directed list operations,
// predicted in the bench and compared beat by beat with every result the block returns.
// Depends on bsl_pkg and the bounded_shifting_list_top RTL.
`timescale 1ns / 1ps
module bounded_shifting_list_top_test import bsl_pkg::*;;

	localparam int LIST_CAP = 32;

	typedef struct {
		kind_t       op;
		logic [4:0]  pos;
		logic [31:0] word;
	} list_op_t;

	typedef struct {
		status_t     st;
		logic [31:0] word;
		logic [5:0]  len;
	} list_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  kind = K_APPEND;
	logic [4:0]  index = '0;
	logic [31:0] value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [31:0] data;
	logic [5:0]  count;

	logic [31:0]  list_mem [LIST_CAP];
	int           list_len = 0;
	list_op_t     pending_ops [$];
	list_result_t expected_results [$];
	list_op_t     next_op;
	list_result_t want;

	logic [31:0] value_pool [8];
	int  in_gap = 0;
	int  out_gap = 0;
	int  in_idle_pct = 0;
	int  out_idle_pct = 0;
	bit  quiet = 1'b0;
	bit  hold_out = 1'b0;
	int  ops_accepted = 0;
	int  results_checked = 0;
	int  full_hits = 0;
	int  mismatches = 0;

	bounded_shifting_list_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .index(index), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .data(data), .count(count)
	);

	always #10 clk = ~clk;

	function automatic list_result_t list_apply(kind_t op, logic [4:0] pos, logic [31:0] word);
		list_result_t r;
		int hit;
		r.st = ST_OK;
		r.word = '0;
		hit = -1;
		for (int i = 0; i < list_len; i++)
			if (hit < 0 && list_mem[i] == word)
				hit = i;
		case (op)
			K_APPEND, K_INSERT: begin
				if (list_len >= LIST_CAP) begin
					r.st = ST_FULL;
				end else if (op == K_APPEND || pos >= list_len) begin
					list_mem[list_len] = word;
					list_len++;
				end else begin
					for (int i = list_len; i > pos; i--)
						list_mem[i] = list_mem[i - 1];
					list_mem[pos] = word;
					list_len++;
				end
			end
			K_REM_VAL, K_REM_AT: begin
				if (op == K_REM_AT)
					hit = (pos < list_len) ? int'(pos) : -1;
				if (hit < 0) begin
					r.st = (op == K_REM_AT) ? ST_RANGE : ST_NOT_FOUND;
				end else begin
					for (int i = hit; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i + 1];
					list_len--;
				end
			end
			K_POP: begin
				if (list_len == 0) begin
					r.st = ST_EMPTY;
				end else begin
					list_len--;
					r.word = list_mem[list_len];
				end
			end
			K_CONTAINS: begin
				if (hit < 0)
					r.st = ST_NOT_FOUND;
			end
			K_READ_AT: begin
				if (pos >= list_len)
					r.st = ST_RANGE;
				else
					r.word = list_mem[pos];
			end
			default: begin
				list_len = 0;
			end
		endcase
		r.len = 6'(list_len);
		return r;
	endfunction

	function automatic list_op_t make_op(kind_t op, logic [4:0] pos, logic [31:0] word);
		list_op_t o;
		o.op = op;
		o.pos = pos;
		o.word = word;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= K_APPEND;
			index <= '0;
			value <= '0;
			in_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(list_apply(kind_t'(kind), index, value));
				ops_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 99) < in_idle_pct) begin
					in_gap = $urandom_range(0, 13);
					in_valid <= 1'b0;
				end else if (pending_ops.size() > 0) begin
					next_op = pending_ops.pop_front();
					in_valid <= 1'b1;
					kind <= next_op.op;
					index <= next_op.pos;
					value <= next_op.word;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_gap = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: status %0d data %h count %0d",
							status, data, count);
				end else begin
					want = expected_results.pop_front();
					results_checked++;
					if (want.st == ST_FULL)
						full_hits++;
					if (status !== want.st || data !== want.word || count !== want.len) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch on result %0d: expected %0d/%h/%0d, got %0d/%h/%0d",
								results_checked, want.st, want.word, want.len,
								status, data, count);
					end
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else if (hold_out) begin
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 99) < out_idle_pct) begin
				out_gap = $urandom_range(0, 13);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// The receiver holds off once for a long stretch so that the block backs up.
	initial begin
		while (ops_accepted < 300)
			@(posedge clk);
		hold_out <= 1'b1;
		repeat (120) @(posedge clk);
		hold_out <= 1'b0;
	end

	initial begin
		#5ms;
		$display("timed out with %0d results outstanding", expected_results.size());
		$display("status: fail");
		$finish;
	end

	initial begin
		int mode;
		int r;
		kind_t op;
		logic [4:0] pos;
		logic [31:0] word;

		value_pool[0] = 32'h0000_0000;
		value_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < 8; i++)
			value_pool[i] = $urandom;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		pending_ops.push_back(make_op(K_POP, 5'd0, 32'h0));
		pending_ops.push_back(make_op(K_REM_VAL, 5'd0, 32'h0));
		pending_ops.push_back(make_op(K_READ_AT, 5'd0, 32'h0));
		pending_ops.push_back(make_op(K_REM_AT, 5'd0, 32'h0));
		pending_ops.push_back(make_op(K_CONTAINS, 5'd0, 32'h0));
		pending_ops.push_back(make_op(K_APPEND, 5'd31, 32'h0000_0000));
		pending_ops.push_back(make_op(K_APPEND, 5'd0, 32'hFFFF_FFFF));
		pending_ops.push_back(make_op(K_APPEND, 5'd7, 32'h5A5A_A5A5));
		pending_ops.push_back(make_op(K_INSERT, 5'd0, 32'h0000_0001));
		pending_ops.push_back(make_op(K_INSERT, 5'd31, 32'h8000_0000));
		pending_ops.push_back(make_op(K_INSERT, 5'd2, 32'h0000_0003));
		pending_ops.push_back(make_op(K_READ_AT, 5'd0, 32'h0));
		pending_ops.push_back(make_op(K_READ_AT, 5'd5, 32'hFFFF_FFFF));
		pending_ops.push_back(make_op(K_READ_AT, 5'd31, 32'h0));
		pending_ops.push_back(make_op(K_CONTAINS, 5'd0, 32'hFFFF_FFFF));
		pending_ops.push_back(make_op(K_CONTAINS, 5'd0, 32'h0000_0007));
		pending_ops.push_back(make_op(K_APPEND, 5'd0, 32'h0000_0003));
		pending_ops.push_back(make_op(K_REM_VAL, 5'd0, 32'h0000_0003));
		pending_ops.push_back(make_op(K_REM_VAL, 5'd0, 32'h1234_5678));
		pending_ops.push_back(make_op(K_REM_AT, 5'd0, 32'h0));
		pending_ops.push_back(make_op(K_REM_AT, 5'd31, 32'h0));
		pending_ops.push_back(make_op(K_POP, 5'd0, 32'h0));
		pending_ops.push_back(make_op(K_CLEAR, 5'd0, 32'h0));
		pending_ops.push_back(make_op(K_POP, 5'd0, 32'h0));

		mode = 0;
		for (int n = 0; n < 750; n++) begin
			while (pending_ops.size() >= 3)
				@(negedge clk);
			if (n % 40 == 0) begin
				mode = $urandom_range(0, 3);
				r = $urandom_range(0, 2);
				in_idle_pct = (r == 0) ? 0 : (r == 1) ? 15 : 40;
				r = $urandom_range(0, 2);
				out_idle_pct = (r == 0) ? 0 : (r == 1) ? 15 : 40;
			end
			if (n >= 640)
				quiet = 1'b1;
			r = $urandom_range(0, 99);
			case (mode)
				0: op = (r < 45) ? K_APPEND : (r < 80) ? K_INSERT : kind_t'($urandom_range(2, 6));
				1: op = (r < 25) ? K_POP : (r < 50) ? K_REM_AT : (r < 75) ? K_REM_VAL :
					kind_t'($urandom_range(0, 6));
				2: op = (r < 3) ? K_CLEAR : kind_t'($urandom_range(0, 6));
				default: op = (r < 55) ? K_APPEND : K_INSERT;
			endcase
			if ($urandom_range(0, 99) < 75)
				pos = 5'($urandom_range(0, list_len > 31 ? 31 : list_len));
			else
				pos = 5'($urandom_range(0, 31));
			word = ($urandom_range(0, 1) == 0) ? value_pool[$urandom_range(0, 7)] : $urandom;
			pending_ops.push_back(make_op(op, pos, word));
		end

		while (pending_ops.size() > 0 || in_valid)
			@(posedge clk);
		while (expected_results.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d operations sent, %0d results checked, %0d rejected as full",
			ops_accepted, results_checked, full_hits);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("status: fail");
		end
		$finish;
	end

endmodule
